// ----- hw/rtl/rpe_pkg.sv -----
package rpe_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int NUM_COEFS = 25;
  localparam int EXT_BASE  = 9;
  localparam int CIW       = 5;

  // divider: numerator |a| << FRAC_BITS, quotient bits kept before saturation
  localparam int NUM_W   = DW + FRAC_BITS;
  localparam int QW      = DW + 1;
  localparam int DIV_LAT = QW + 2;

  // square root: one result bit per stage
  localparam int SQ_STEPS = DW;
  localparam int SQ_RW    = DW + 4;
  localparam int SQ_LAT   = SQ_STEPS;

  // product after the fraction shift, and a sum of up to four of them
  localparam int PW = 2 * DW - FRAC_BITS;
  localparam int SW = PW + 2;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int BACK_LAT = 2 + DIV_LAT + 2 + DIV_LAT + 3 + SQ_LAT + 1;
  localparam int INFL_W   = $clog2(QDEPTH + BACK_LAT + 2);

  typedef logic signed [DW-1:0] q_t;

  localparam q_t QMAX = {1'b0, {(DW-1){1'b1}}};
  localparam q_t QMIN = {1'b1, {(DW-1){1'b0}}};

  localparam logic [DW-1:0] THR_RESET = DW'(3) << FRAC_BITS;

  typedef enum logic {
    REQ_COEF = 1'b0,
    REQ_TEST = 1'b1
  } req_e;

  typedef logic [NUM_COEFS-1:0][DW-1:0] coef_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic signed [DW-1:0] u;
    logic signed [DW-1:0] v;
  } pt_t;

  typedef struct packed {
    logic                 vld;
    logic                 fault;
    logic                 sat;
    logic signed [DW-1:0] u;
    logic signed [DW-1:0] v;
  } side_t;

endpackage

// ----- hw/rtl/rpe_req_if.sv -----
interface rpe_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [4:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] ref_x;
  logic signed [31:0] ref_y;
  logic signed [31:0] ref_z;
  logic signed [31:0] scene_u;
  logic signed [31:0] scene_v;

  modport source (
    output valid, req_type, coef_index, coef_value, ref_x, ref_y, ref_z, scene_u, scene_v,
    input  ready
  );
  modport sink (
    input  valid, req_type, coef_index, coef_value, ref_x, ref_y, ref_z, scene_u, scene_v,
    output ready
  );
endinterface

// ----- hw/rtl/rpe_res_if.sv -----
interface rpe_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] error_distance;
  logic        is_inlier;
  logic        divide_fault;

  modport source (
    output valid, error_distance, is_inlier, divide_fault,
    input  ready
  );
  modport sink (
    input  valid, error_distance, is_inlier, divide_fault,
    output ready
  );
endinterface

// ----- hw/rtl/rpe_front.sv -----
module rpe_front import rpe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  rpe_req_if.sink req_i,
  input  logic    done_i,
  output pt_t     pt_o,
  output logic    pt_vld_o,
  input  logic    pt_rdy_i,
  output coef_t   coef_o
);

  q_t                coef_q [NUM_COEFS];
  pt_t               fifo_q [QDEPTH];
  logic [QAW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QAW:0]      cnt_q, cnt_d;
  logic [INFL_W-1:0] infl_q, infl_d;
  logic              is_test, acc, push, pop;

  assign is_test     = (req_i.req_type == REQ_TEST);
  // coefficient writes wait until no test transaction is in flight
  assign req_i.ready = is_test ? (cnt_q != (QAW+1)'(QDEPTH)) : (infl_q == '0);
  assign acc         = req_i.valid && req_i.ready;
  assign push        = acc && is_test;
  assign pop         = pt_vld_o && pt_rdy_i;

  assign pt_vld_o = (cnt_q != '0);
  assign pt_o     = fifo_q[rd_ptr_q];

  always_comb begin
    for (int i = 0; i < NUM_COEFS; i++) begin
      coef_o[i] = coef_q[i];
    end
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
    infl_d   = infl_q + INFL_W'(push) - INFL_W'(done_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      infl_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      infl_q   <= infl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= pt_t'{x: req_i.ref_x, y: req_i.ref_y, z: req_i.ref_z,
                                u: req_i.scene_u, v: req_i.scene_v};
    end
    if (acc && !is_test && (req_i.coef_index < CIW'(NUM_COEFS))) begin
      coef_q[req_i.coef_index] <= req_i.coef_value;
    end
  end

endmodule

// ----- hw/rtl/rpe_qdiv.sv -----
module rpe_qdiv import rpe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [2:0][DW-1:0]  a_i,
  input  q_t                  b_i,
  input  side_t               side_i,
  output logic [2:0][DW-1:0]  q_o,
  output side_t               side_o
);

  function automatic logic [DW-1:0] abs_q(input logic [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : v;
  endfunction

  function automatic logic [DW+QW-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [QW-1:0] nq,
                                                input logic [DW-1:0] d);
    logic [DW:0] t;
    t = {rem, nq[QW-1]};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      return {t[DW-1:0], nq[QW-2:0], 1'b1};
    end
    return {t[DW-1:0], nq[QW-2:0], 1'b0};
  endfunction

  function automatic q_t div_fix(input logic sgn, input logic ovf, input logic [QW-1:0] q);
    if (ovf) return sgn ? QMIN : QMAX;
    if (!sgn) return (q > QW'(QMAX)) ? QMAX : q_t'(q[DW-1:0]);
    return (q > {1'b0, QMIN}) ? QMIN : q_t'(DW'(-q));
  endfunction

  logic [DW-1:0]    absb;
  logic [NUM_W-1:0] n_w   [3];
  logic [DW-1:0]    d_q   [QW+1];
  logic [DW-1:0]    rem_q [QW+1][3];
  logic [QW-1:0]    nq_q  [QW+1][3];
  logic             sgn_q [QW+1][3];
  logic             ovf_q [QW+1][3];
  q_t               q_q   [3];
  side_t            side_q [DIV_LAT];

  always_comb begin
    absb = abs_q(b_i);
    for (int l = 0; l < 3; l++) begin
      n_w[l] = {abs_q(a_i[l]), {FRAC_BITS{1'b0}}};
      q_o[l] = q_q[l];
    end
  end

  assign side_o = side_q[DIV_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) side_q[k] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < DIV_LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= absb;
      for (int l = 0; l < 3; l++) begin
        sgn_q[0][l] <= a_i[l][DW-1] ^ b_i[DW-1];
        ovf_q[0][l] <= (n_w[l] >> QW) >= NUM_W'(absb);
        rem_q[0][l] <= DW'(n_w[l] >> QW);
        nq_q[0][l]  <= n_w[l][QW-1:0];
      end
      for (int k = 1; k <= QW; k++) begin
        d_q[k] <= d_q[k-1];
        for (int l = 0; l < 3; l++) begin
          sgn_q[k][l]               <= sgn_q[k-1][l];
          ovf_q[k][l]               <= ovf_q[k-1][l];
          {rem_q[k][l], nq_q[k][l]} <= div_step(rem_q[k-1][l], nq_q[k-1][l], d_q[k-1]);
        end
      end
      for (int l = 0; l < 3; l++) begin
        q_q[l] <= div_fix(sgn_q[QW][l], ovf_q[QW][l], nq_q[QW][l]);
      end
    end
  end

endmodule

// ----- hw/rtl/rpe_isqrt.sv -----
module rpe_isqrt import rpe_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [2*DW-1:0] n_i,
  input  side_t           side_i,
  output logic [DW-1:0]   root_o,
  output side_t           side_o
);

  logic [SQ_RW-1:0] rin_w  [SQ_STEPS];
  logic [DW-1:0]    oin_w  [SQ_STEPS];
  logic [2*DW-1:0]  nin_w  [SQ_STEPS];
  logic [SQ_RW-1:0] rt_w   [SQ_STEPS];
  logic [SQ_RW-1:0] tr_w   [SQ_STEPS];
  logic [SQ_RW-1:0] rem_d  [SQ_STEPS];
  logic [DW-1:0]    root_d [SQ_STEPS];
  logic [SQ_RW-1:0] rem_q  [SQ_STEPS];
  logic [DW-1:0]    root_q [SQ_STEPS];
  logic [2*DW-1:0]  nn_q   [SQ_STEPS];
  side_t            side_q [SQ_STEPS];

  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      if (k == 0) begin
        rin_w[k] = '0;
        oin_w[k] = '0;
        nin_w[k] = n_i;
      end else begin
        rin_w[k] = rem_q[k-1];
        oin_w[k] = root_q[k-1];
        nin_w[k] = nn_q[k-1];
      end
      rt_w[k] = {rin_w[k][SQ_RW-3:0], nin_w[k][2*DW-1 -: 2]};
      tr_w[k] = SQ_RW'({oin_w[k], 2'b01});
      if (rt_w[k] >= tr_w[k]) begin
        rem_d[k]  = rt_w[k] - tr_w[k];
        root_d[k] = {oin_w[k][DW-2:0], 1'b1};
      end else begin
        rem_d[k]  = rt_w[k];
        root_d[k] = {oin_w[k][DW-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_q[SQ_STEPS-1];
  assign side_o = side_q[SQ_STEPS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQ_STEPS; k++) side_q[k] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < SQ_STEPS; k++) side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        nn_q[k]   <= nin_w[k] << 2;
      end
    end
  end

endmodule

// ----- hw/rtl/rpe_back.sv -----
module rpe_back import rpe_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pt_t           pt_i,
  input  logic          pt_vld_i,
  output logic          pt_rdy_o,
  input  coef_t         coef_i,
  input  logic [DW-1:0] thr_i,
  rpe_res_if.source     res_o,
  output logic          done_o
);

  function automatic q_t sat_q(input logic signed [SW-1:0] v);
    if (v > SW'(QMAX)) return QMAX;
    if (v < SW'(QMIN)) return QMIN;
    return q_t'(v[DW-1:0]);
  endfunction

  logic adv;

  q_t                     pt_w      [3];
  logic signed [2*DW-1:0] e_prod    [4][3];
  logic signed [PW-1:0]   s1_prod_q [4][3];
  q_t                     s1_e3_q   [4];
  side_t                  s1_side_q;

  logic signed [SW-1:0]   cam_sum   [4];
  q_t                     s2_cam_q  [4];
  side_t                  s2_side_q;

  side_t                  d1_in, d1_side;
  logic [2:0][DW-1:0]     d1_q;

  logic signed [2*DW-1:0] k_prod    [3][3];
  logic signed [PW-1:0]   s3_prod_q [3][3];
  side_t                  s3_side_q;

  logic signed [SW-1:0]   img_sum   [3];
  q_t                     s4_img_q  [3];
  side_t                  s4_side_q;

  side_t                  d2_in, d2_side;
  logic [2:0][DW-1:0]     d2_q;

  logic signed [DW:0]     dx, dy;
  logic [DW:0]            ax, ay;
  logic [DW-1:0]          s5_ax_q, s5_ay_q;
  side_t                  s5_side_d, s5_side_q;

  logic [2*DW-1:0]        s6_sx_q, s6_sy_q;
  side_t                  s6_side_q;

  logic [2*DW:0]          sum_w;
  logic [2*DW-1:0]        s7_sum_q;
  side_t                  s7_side_d, s7_side_q;

  logic [DW-1:0]          root;
  side_t                  sq_side;
  logic [DW-1:0]          err_w;

  logic                   out_vld_q;
  logic [DW-1:0]          out_err_q;
  logic                   out_inl_q, out_flt_q;

  assign adv      = !out_vld_q || res_o.ready;
  assign pt_rdy_o = adv;
  assign done_o   = res_o.valid && res_o.ready;

  // extrinsic transform, then sum and saturate
  always_comb begin
    pt_w[0] = pt_i.x;
    pt_w[1] = pt_i.y;
    pt_w[2] = pt_i.z;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        e_prod[r][c] = $signed(coef_i[EXT_BASE + 4*r + c]) * pt_w[c];
      end
      cam_sum[r] = SW'(s1_prod_q[r][0]) + SW'(s1_prod_q[r][1]) + SW'(s1_prod_q[r][2])
                 + SW'(s1_e3_q[r]);
    end
  end

  always_comb begin
    d1_in       = s2_side_q;
    d1_in.fault = s2_side_q.fault || (s2_cam_q[3] == '0);
  end

  rpe_qdiv u_div_nrm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .a_i    ({s2_cam_q[2], s2_cam_q[1], s2_cam_q[0]}),
    .b_i    (s2_cam_q[3]),
    .side_i (d1_in),
    .q_o    (d1_q),
    .side_o (d1_side)
  );

  // intrinsic transform
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        k_prod[r][c] = $signed(coef_i[3*r + c]) * $signed(d1_q[c]);
      end
      img_sum[r] = SW'(s3_prod_q[r][0]) + SW'(s3_prod_q[r][1]) + SW'(s3_prod_q[r][2]);
    end
  end

  always_comb begin
    d2_in       = s4_side_q;
    d2_in.fault = s4_side_q.fault || (s4_img_q[2] == '0);
  end

  // lane 2 divides depth by itself and is not used
  rpe_qdiv u_div_img (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .a_i    ({s4_img_q[2], s4_img_q[1], s4_img_q[0]}),
    .b_i    (s4_img_q[2]),
    .side_i (d2_in),
    .q_o    (d2_q),
    .side_o (d2_side)
  );

  // distance to the observed point
  always_comb begin
    dx            = {d2_q[0][DW-1], d2_q[0]} - {d2_side.u[DW-1], d2_side.u};
    dy            = {d2_q[1][DW-1], d2_q[1]} - {d2_side.v[DW-1], d2_side.v};
    ax            = dx[DW] ? (DW+1)'(-dx) : dx;
    ay            = dy[DW] ? (DW+1)'(-dy) : dy;
    s5_side_d     = d2_side;
    s5_side_d.sat = ax[DW] || ay[DW];
    sum_w         = (2*DW+1)'(s6_sx_q) + (2*DW+1)'(s6_sy_q);
    s7_side_d     = s6_side_q;
    s7_side_d.sat = s6_side_q.sat || sum_w[2*DW];
  end

  rpe_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .n_i    (s7_sum_q),
    .side_i (s7_side_q),
    .root_o (root),
    .side_o (sq_side)
  );

  assign err_w = (sq_side.fault || sq_side.sat) ? '1 : root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_side_q <= '0;
      s2_side_q <= '0;
      s3_side_q <= '0;
      s4_side_q <= '0;
      s5_side_q <= '0;
      s6_side_q <= '0;
      s7_side_q <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_side_q <= side_t'{vld: pt_vld_i, fault: 1'b0, sat: 1'b0, u: pt_i.u, v: pt_i.v};
      s2_side_q <= s1_side_q;
      s3_side_q <= d1_side;
      s4_side_q <= s3_side_q;
      s5_side_q <= s5_side_d;
      s6_side_q <= s5_side_q;
      s7_side_q <= s7_side_d;
      out_vld_q <= sq_side.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          s1_prod_q[r][c] <= e_prod[r][c][2*DW-1:FRAC_BITS];
        end
        s1_e3_q[r]  <= $signed(coef_i[EXT_BASE + 4*r + 3]);
        s2_cam_q[r] <= sat_q(cam_sum[r]);
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s3_prod_q[r][c] <= k_prod[r][c][2*DW-1:FRAC_BITS];
        end
        s4_img_q[r] <= sat_q(img_sum[r]);
      end
      s5_ax_q   <= ax[DW-1:0];
      s5_ay_q   <= ay[DW-1:0];
      s6_sx_q   <= (2*DW)'(s5_ax_q) * (2*DW)'(s5_ax_q);
      s6_sy_q   <= (2*DW)'(s5_ay_q) * (2*DW)'(s5_ay_q);
      s7_sum_q  <= sum_w[2*DW-1:0];
      out_err_q <= err_w;
      out_inl_q <= !sq_side.fault && (err_w < thr_i);
      out_flt_q <= sq_side.fault;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.error_distance = out_err_q;
  assign res_o.is_inlier      = out_inl_q;
  assign res_o.divide_fault   = out_flt_q;

endmodule

// ----- hw/rtl/reprojection_error_inlier_test.sv -----
// A point test passes the queue, two 35-stage divide pipelines, a 32-stage square
// root and 8 other stages. Throughput: one point test or coefficient write per
// cycle while the queue has room and results are taken; a coefficient write waits
// until every earlier point test has delivered its result.
// Reset: control state and the output slot clear; threshold resets to 3.0;
// coefficients are undefined until written.
module reprojection_error_inlier_test import rpe_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  rpe_req_if.sink       req_i,
  rpe_res_if.source     res_o,
  input  logic          cfg_we_i,
  input  logic [DW-1:0] cfg_wdata_i
);

  logic [DW-1:0] thr_q;
  pt_t           pt;
  logic          pt_vld, pt_rdy, done;
  coef_t         coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  rpe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .done_i   (done),
    .pt_o     (pt),
    .pt_vld_o (pt_vld),
    .pt_rdy_i (pt_rdy),
    .coef_o   (coef)
  );

  rpe_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pt_i     (pt),
    .pt_vld_i (pt_vld),
    .pt_rdy_o (pt_rdy),
    .coef_i   (coef),
    .thr_i    (thr_q),
    .res_o    (res_o),
    .done_o   (done)
  );

  a_fault_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.divide_fault |-> (res_o.error_distance == '1) && !res_o.is_inlier)
    else $error("fault result not saturated");

  a_inlier_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.is_inlier |-> res_o.error_distance < thr_q)
    else $error("inlier at or above threshold");

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && (req_i.req_type == REQ_COEF) |-> !res_o.valid)
    else $error("coefficient write taken with a result pending");

endmodule
